FILE: sv/wavetable_voice_mixer_with_envelope_core_defines.svh
// Assertion macros for the wavetable voice mixer core
`ifndef WAVETABLE_VOICE_MIXER_WITH_ENVELOPE_CORE_DEFINES_SVH
`define WAVETABLE_VOICE_MIXER_WITH_ENVELOPE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define WVM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wvm check failed: same-cycle rule");

// Next-cycle implication, checked out of reset
`define WVM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wvm check failed: next-cycle rule");

`endif

FILE: sv/wvm_pkg.sv
// Shared types, constants and helper functions of the wavetable voice mixer
package wvm_pkg;

   localparam int FRET_W    = 6;
   localparam int VOICE_W   = 3;
   localparam int STEP_W    = 26;
   localparam int SAMPLE_W  = 16;
   localparam int LEVEL_W   = 16;
   localparam int CSTEP_W   = 22;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 22;
   localparam int CUR_W     = 24;
   localparam int FRAC_W    = 22;

   localparam logic [CUR_W-1:0] CUR_TWO   = 24'd8388608;
   localparam logic [CUR_W-1:0] CUR_THREE = 24'd12582912;
   localparam logic [FRAC_W-1:0] CUR_FRAC = 22'h3FFFFF;
   localparam logic [63:0] HALF_PI_Q62    = 64'h6487ED5110B4611A;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CSTEP  = 3'd4;

   // Datapath operation codes
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_LOAD   = 4'd1;
   localparam logic [3:0] OP_REDUCE = 4'd2;
   localparam logic [3:0] OP_COMMIT = 4'd3;
   localparam logic [3:0] OP_CLEAR  = 4'd4;
   localparam logic [3:0] OP_PHASE  = 4'd5;
   localparam logic [3:0] OP_MUL1   = 4'd6;
   localparam logic [3:0] OP_AMP    = 4'd7;
   localparam logic [3:0] OP_MUL2   = 4'd8;
   localparam logic [3:0] OP_ACC    = 4'd9;
   localparam logic [3:0] OP_OUT    = 4'd10;

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic voice_on;
      logic reduce_done;
      logic rsp_busy;
   } status_type;

   // Q62 fixed-point product, used only on constants
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[125:62];
   endfunction

endpackage

FILE: sv/wvm_if.sv
// Channel interfaces: request items, result items and register writes
interface wvm_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [wvm_pkg::VOICE_W-1:0]  voice;
   logic signed [wvm_pkg::FRET_W-1:0] fret;
   logic [wvm_pkg::STEP_W-1:0]   phase_step;
   modport source (output valid, action, voice, fret, phase_step, input ready);
   modport sink   (input valid, action, voice, fret, phase_step, output ready);
endinterface

interface wvm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [wvm_pkg::SAMPLE_W-1:0] sample;
   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

interface wvm_csr_if;
   logic                           valid;
   logic                           ready;
   logic [wvm_pkg::CSR_IDX_W-1:0]  index;
   logic [wvm_pkg::CSR_DAT_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/wvm_ctrl.sv
// Sequencer: walks set-tone and tick items through the datapath
module wvm_ctrl #(
   parameter int VOICES = 6,
   parameter int VIW    = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_ready,
   input  wvm_pkg::status_type  status,
   output wvm_pkg::cmd_type     cmd,
   output logic [VIW-1:0]       voice_idx
);
   import wvm_pkg::*;

   localparam int VCW = $clog2(VOICES + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_REDUCE = 4'd1;
   localparam logic [3:0] S_COMMIT = 4'd2;
   localparam logic [3:0] S_CHECK  = 4'd3;
   localparam logic [3:0] S_MUL1   = 4'd4;
   localparam logic [3:0] S_AMP    = 4'd5;
   localparam logic [3:0] S_MUL2   = 4'd6;
   localparam logic [3:0] S_ACC    = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;

   logic [3:0]     state_ff, state_in;
   logic [VCW-1:0] vcnt_ff, vcnt_in;
   logic           last_voice;

   assign last_voice = (vcnt_ff == VCW'(VOICES - 1));
   assign voice_idx  = vcnt_ff[VIW-1:0];
   assign req_ready  = (state_ff == S_IDLE);

   // Next state and datapath command
   always_comb begin
      state_in = state_ff;
      vcnt_in  = vcnt_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op  = OP_LOAD;
               vcnt_in = '0;
               state_in = req_action ? S_REDUCE : S_CHECK;
            end
         end
         S_REDUCE: begin
            if (status.reduce_done) begin
               state_in = S_COMMIT;
            end else begin
               cmd.op = OP_REDUCE;
            end
         end
         S_COMMIT: begin
            cmd.op   = OP_COMMIT;
            state_in = S_IDLE;
         end
         S_CHECK: begin
            if (status.voice_on) begin
               cmd.op   = OP_PHASE;
               state_in = S_MUL1;
            end else if (last_voice) begin
               state_in = S_OUT;
            end else begin
               vcnt_in = vcnt_ff + 1'b1;
            end
         end
         S_MUL1: begin
            cmd.op   = OP_MUL1;
            state_in = S_AMP;
         end
         S_AMP: begin
            cmd.op   = OP_AMP;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.op   = OP_MUL2;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op = OP_ACC;
            if (last_voice) begin
               state_in = S_OUT;
            end else begin
               vcnt_in  = vcnt_ff + 1'b1;
               state_in = S_CHECK;
            end
         end
         S_OUT: begin
            // hold the sample until the result register is free
            if (!status.rsp_busy) begin
               cmd.op   = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         vcnt_ff  <= vcnt_in;
      end
   end

endmodule

FILE: sv/wvm_dp.sv
// Datapath: voice state, sine table, envelope interpolation and mixing
module wvm_dp #(
   parameter int VOICES     = 6,
   parameter int TABLE_SIZE = 1024,
   parameter int VIW        = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   wvm_req_if.sink              req_bus,
   wvm_rsp_if.source            rsp_bus,
   wvm_csr_if.sink              csr_bus,
   input  wvm_pkg::cmd_type     cmd,
   input  logic [VIW-1:0]       voice_idx,
   output wvm_pkg::status_type  status
);
   import wvm_pkg::*;

   localparam int TW = $clog2(TABLE_SIZE);
   localparam int PW = TW + 16;
   localparam int WW = (PW > STEP_W) ? PW : STEP_W;
   localparam logic [WW:0] WRAP_W = (WW + 1)'(TABLE_SIZE) << 16;
   localparam logic [PW:0] WRAP_P = (PW + 1)'(TABLE_SIZE) << 16;

   // Sine table, built at elaboration from a Taylor series in Q62
   logic [SAMPLE_W-1:0] rom_tab [TABLE_SIZE];
   for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_rom
      localparam int unsigned M  = 4 * gi;
      localparam int unsigned Q  = M / TABLE_SIZE;
      localparam int unsigned R0 = M % TABLE_SIZE;
      localparam int unsigned R  = (Q % 2 == 1) ? TABLE_SIZE - R0 : R0;
      localparam logic [63:0] X  = (HALF_PI_Q62 / TABLE_SIZE) * 64'(R)
                                 + ((HALF_PI_Q62 % TABLE_SIZE) * 64'(R)) / TABLE_SIZE;
      localparam logic [63:0] X2  = mul_q62(X, X);
      localparam logic [63:0] T1  = mul_q62(X, X2) / 64'd6;
      localparam logic [63:0] T2  = mul_q62(T1, X2) / 64'd20;
      localparam logic [63:0] T3  = mul_q62(T2, X2) / 64'd42;
      localparam logic [63:0] T4  = mul_q62(T3, X2) / 64'd72;
      localparam logic [63:0] T5  = mul_q62(T4, X2) / 64'd110;
      localparam logic [63:0] T6  = mul_q62(T5, X2) / 64'd156;
      localparam logic [63:0] T7  = mul_q62(T6, X2) / 64'd210;
      localparam logic [63:0] T8  = mul_q62(T7, X2) / 64'd272;
      localparam logic [63:0] T9  = mul_q62(T8, X2) / 64'd342;
      localparam logic [63:0] T10 = mul_q62(T9, X2) / 64'd420;
      localparam logic [63:0] T11 = mul_q62(T10, X2) / 64'd506;
      localparam logic [63:0] T12 = mul_q62(T11, X2) / 64'd600;
      localparam logic [63:0] SUM = X - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9
                                  + T10 - T11 + T12 + 64'd1024;
      localparam logic [63:0] MAG = mul_q62(SUM, 64'd32767);
      localparam logic [15:0] MC  = (MAG > 64'd32767) ? 16'd32767 : MAG[15:0];
      localparam logic [15:0] VAL = (Q >= 2) ? 16'(~MC + 16'd1) : MC;
      assign rom_tab[gi] = VAL;
   end

   // Configuration registers
   logic [LEVEL_W-1:0] lvl0_ff, lvl1_ff, lvl2_ff, lvl3_ff;
   logic [CSTEP_W-1:0] cstep_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl0_ff  <= 16'd0;
         lvl1_ff  <= 16'd32768;
         lvl2_ff  <= 16'd16384;
         lvl3_ff  <= 16'd0;
         cstep_ff <= 22'd175;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_LEVEL0: lvl0_ff  <= csr_bus.data[LEVEL_W-1:0];
            REG_LEVEL1: lvl1_ff  <= csr_bus.data[LEVEL_W-1:0];
            REG_LEVEL2: lvl2_ff  <= csr_bus.data[LEVEL_W-1:0];
            REG_LEVEL3: lvl3_ff  <= csr_bus.data[LEVEL_W-1:0];
            REG_CSTEP:  cstep_ff <= csr_bus.data[CSTEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Latched request item
   logic                     act_ff;
   logic [VOICE_W-1:0]       voice_ff;
   logic signed [FRET_W-1:0] fret_ff;
   logic [WW-1:0]            work_ff;

   // Per-voice state
   logic              on_ff    [VOICES];
   logic [FRET_W-1:0] sound_ff [VOICES];
   logic [PW-1:0]     step_ff  [VOICES];
   logic [PW-1:0]     phase_ff [VOICES];
   logic [CUR_W-1:0]  cur_ff   [VOICES];

   // Tick pipeline registers
   logic [TW-1:0]           idx_ff;
   logic [LEVEL_W-1:0]      la_ff, lb_ff, amp_ff;
   logic [FRAC_W-1:0]       frac_ff;
   logic                    at3_ff, down_ff;
   logic [FRAC_W+LEVEL_W-1:0] p1_ff;
   logic signed [SAMPLE_W-1:0] rom_ff;
   logic signed [SAMPLE_W+LEVEL_W:0] p2_ff;
   logic [SAMPLE_W-1:0]     acc_ff;
   logic                    rsp_valid_ff;
   logic [SAMPLE_W-1:0]     sample_ff;

   // Set-tone decode
   logic [4:0]       vext;
   logic             v_ok;
   logic [VIW-1:0]   wv;

   assign vext = 5'(voice_ff);
   assign v_ok = (vext < 5'(VOICES));
   assign wv   = vext[VIW-1:0];

   // Phase and cursor update for the selected voice
   logic [PW:0]      ph_sum, ph_new;
   logic [CUR_W-1:0] c_old, c_eff;
   logic [CUR_W:0]   c_add;
   logic             hold;
   logic [1:0]       node;
   logic [LEVEL_W-1:0] lv_a, lv_b;

   always_comb begin
      ph_sum = {1'b0, phase_ff[voice_idx]} + {1'b0, step_ff[voice_idx]};
      ph_new = (ph_sum >= WRAP_P) ? ph_sum - WRAP_P : ph_sum;
      c_old  = cur_ff[voice_idx];
      hold   = (c_old > CUR_TWO) && (c_old < CUR_THREE);
      c_add  = {1'b0, c_old} + (CUR_W + 1)'(cstep_ff);
      if (hold) begin
         c_eff = c_old;
      end else if (c_add >= {1'b0, CUR_THREE}) begin
         c_eff = CUR_THREE;
      end else begin
         c_eff = c_add[CUR_W-1:0];
      end
      node = c_eff[CUR_W-1:FRAC_W];
      case (node)
         2'd0: begin lv_a = lvl0_ff; lv_b = lvl1_ff; end
         2'd1: begin lv_a = lvl1_ff; lv_b = lvl2_ff; end
         2'd2: begin lv_a = lvl2_ff; lv_b = lvl3_ff; end
         default: begin lv_a = lvl3_ff; lv_b = lvl3_ff; end
      endcase
   end

   // Amplitude and contribution arithmetic
   logic [LEVEL_W-1:0] diff;
   logic [LEVEL_W-1:0] amp_dn, amp_up;
   logic [FRAC_W+LEVEL_W:0] p1_rnd;
   logic signed [SAMPLE_W+LEVEL_W+1:0] p2_adj;
   logic [SAMPLE_W+LEVEL_W+1:0] quot;

   always_comb begin
      diff   = (lb_ff >= la_ff) ? lb_ff - la_ff : la_ff - lb_ff;
      p1_rnd = {1'b0, p1_ff} + (FRAC_W + LEVEL_W + 1)'(CUR_FRAC);
      amp_up = la_ff + LEVEL_W'(p1_ff >> FRAC_W);
      amp_dn = la_ff - LEVEL_W'(p1_rnd >> FRAC_W);
      p2_adj = (SAMPLE_W + LEVEL_W + 2)'(p2_ff)
             + ((p2_ff < 0) ? (SAMPLE_W + LEVEL_W + 2)'(32767) : '0);
      quot   = p2_adj >>> 15;
   end

   // Item latch, step reduction and result register
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            act_ff   <= req_bus.action;
            voice_ff <= req_bus.voice;
            fret_ff  <= req_bus.fret;
            work_ff  <= WW'(req_bus.phase_step);
            acc_ff   <= '0;
         end
         OP_REDUCE: work_ff <= WW'({1'b0, work_ff} - WRAP_W);
         OP_PHASE: begin
            idx_ff  <= ph_new[PW-1:16];
            la_ff   <= (c_eff >= CUR_THREE) ? lvl3_ff : lv_a;
            lb_ff   <= (c_eff >= CUR_THREE) ? lvl3_ff : lv_b;
            frac_ff <= c_eff[FRAC_W-1:0];
            at3_ff  <= (c_eff >= CUR_THREE);
         end
         OP_MUL1: begin
            p1_ff   <= (FRAC_W + LEVEL_W)'(frac_ff) * (FRAC_W + LEVEL_W)'(diff);
            down_ff <= (lb_ff < la_ff);
            rom_ff  <= rom_tab[idx_ff];
         end
         OP_AMP: amp_ff <= at3_ff ? lvl3_ff : (down_ff ? amp_dn : amp_up);
         OP_MUL2: p2_ff <= rom_ff * $signed({1'b0, amp_ff});
         OP_ACC: acc_ff <= acc_ff + quot[SAMPLE_W-1:0];
         OP_OUT: sample_ff <= acc_ff;
         default: ;
      endcase
   end

   // Voice state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VOICES; i++) begin
            on_ff[i]    <= 1'b0;
            sound_ff[i] <= '1;
            step_ff[i]  <= '0;
            phase_ff[i] <= '0;
            cur_ff[i]   <= '0;
         end
      end else if (cmd.op == OP_COMMIT) begin
         if (act_ff && v_ok) begin
            if (fret_ff < 0) begin
               on_ff[wv] <= 1'b0;
            end else begin
               on_ff[wv] <= 1'b1;
               if (fret_ff != $signed(sound_ff[wv])) begin
                  step_ff[wv]  <= work_ff[PW-1:0];
                  cur_ff[wv]   <= '0;
                  sound_ff[wv] <= fret_ff;
               end
            end
         end
      end else if (cmd.op == OP_PHASE) begin
         phase_ff[voice_idx] <= ph_new[PW-1:0];
         cur_ff[voice_idx]   <= c_eff;
      end
   end

   // Result valid: set on a finished tick, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.sample = sample_ff;

   assign status.voice_on    = on_ff[voice_idx];
   assign status.reduce_done = ({1'b0, work_ff} < WRAP_W);
   assign status.rsp_busy    = rsp_valid_ff && !rsp_bus.ready;

endmodule

FILE: sv/wavetable_voice_mixer_with_envelope_core.sv
// A tick item visits each voice in turn: a sounding voice passes through phase, first multiply,
//   amplitude, second multiply and accumulate, a muted voice is skipped; then the sample is output.
// One item at a time: the input closes on acceptance and reopens when a tick's sample is output,
//   or when a set-tone item is committed after each table wrap is folded out of its phase step.
// A waiting sample stalls only the output step of the next tick, which keeps the input closed meanwhile.
// Reset is synchronous: voices muted, phases and cursors cleared, levels to defaults.
`include "wavetable_voice_mixer_with_envelope_core_defines.svh"
module wavetable_voice_mixer_with_envelope_core #(
   parameter int VOICES     = 6,
   parameter int TABLE_SIZE = 1024
) (
   input  logic       clock,
   input  logic       reset,
   wvm_req_if.sink    req_bus,
   wvm_rsp_if.source  rsp_bus,
   wvm_csr_if.sink    csr_bus
);
   import wvm_pkg::*;

   localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;

   cmd_type        cmd;
   status_type     status;
   logic [VIW-1:0] voice_idx;
   logic           req_ready;

   assign req_bus.ready = req_ready;

   // Sequencer
   wvm_ctrl #(.VOICES(VOICES), .VIW(VIW)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_action (req_bus.action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd),
      .voice_idx  (voice_idx)
   );

   // Datapath
   wvm_dp #(.VOICES(VOICES), .TABLE_SIZE(TABLE_SIZE), .VIW(VIW)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_bus   (csr_bus),
      .cmd       (cmd),
      .voice_idx (voice_idx),
      .status    (status)
   );

   // An accepted item closes the input in the cycle after acceptance
   `WVM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready)
   // A new sample never overwrites one still waiting
   `WVM_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.op == OP_OUT, !(rsp_bus.valid && !rsp_bus.ready))
   // A taken sample is gone unless a new one lands on the same edge
   `WVM_ASSERT_NEXT(a_drop_after_take, clock, reset, rsp_bus.valid && rsp_bus.ready && cmd.op != OP_OUT, !rsp_bus.valid)

endmodule
